// ===== rtl/core/cafr_pkg.sv =====
// Shared types and constants of the checked ASCII frame receiver.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package cafr_pkg;

   localparam int CAFR_MAX_WORDS = 32;

   // Response queue between the word store and the response port.
   localparam int RSPQ_DEPTH = 4;
   localparam int RSPQ_PTR_W = 2;
   localparam int RSPQ_LVL_W = 3;

   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_STATION_ADDRESS = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAK_RETRY_LIMIT = 4'd1;

   localparam logic [31:0] STATION_ADDRESS_RESET = 32'd1;
   localparam logic [7:0]  NAK_RETRY_LIMIT_RESET = 8'd3;

   localparam logic [7:0] CH_STX   = 8'h02;
   localparam logic [7:0] CH_ETX   = 8'h03;
   localparam logic [7:0] CH_ACK   = 8'h06;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_NAK   = 8'h15;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef enum logic [1:0] {
      KIND_ACK    = 2'd0,
      KIND_NAK    = 2'd1,
      KIND_RESEND = 2'd2,
      KIND_WORD   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SKIP1,
      PH_SUM,
      PH_SKIP2,
      PH_MIX,
      PH_PAYLOAD,
      PH_CHECK
   } phase_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] word_value;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type item;
   } rsp_push_type;

   typedef struct packed {
      logic room;
      logic draining;
   } store_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/cafr_rsp_queue.sv =====
// Small response queue that decouples result production from the response port.
// Depends on cafr_pkg.
`default_nettype none

module cafr_rsp_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  cafr_pkg::rsp_push_type            push,
   output logic [cafr_pkg::RSPQ_LVL_W-1:0]   level,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output cafr_pkg::rsp_type                 rsp_data
);
   import cafr_pkg::*;

   rsp_type                entry_ff [RSPQ_DEPTH];
   logic [RSPQ_PTR_W-1:0]  wr_ptr_ff;
   logic [RSPQ_PTR_W-1:0]  wr_ptr_in;
   logic [RSPQ_PTR_W-1:0]  rd_ptr_ff;
   logic [RSPQ_PTR_W-1:0]  rd_ptr_in;
   logic [RSPQ_LVL_W-1:0]  level_ff;
   logic [RSPQ_LVL_W-1:0]  level_in;
   logic                   pop;

   assign rsp_valid = (level_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign level     = level_ff;
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + RSPQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + RSPQ_PTR_W'(1) : rd_ptr_ff;
      level_in  = level_ff + RSPQ_LVL_W'(push.valid) - RSPQ_LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/cafr_word_store.sv =====
// Word memory with its drain sequencer; merges drained words with parser results.
// Depends on cafr_pkg.
`default_nettype none

module cafr_word_store #(
   parameter  int MAX_WORDS = cafr_pkg::CAFR_MAX_WORDS,
   localparam int AW        = $clog2(MAX_WORDS),
   localparam int CW        = $clog2(MAX_WORDS + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_en,
   input  logic [AW-1:0]                     wr_addr,
   input  logic [31:0]                       wr_data,
   input  logic                              drain_go,
   input  logic [CW-1:0]                     drain_count,
   input  cafr_pkg::rsp_push_type            parser_push,
   input  logic [cafr_pkg::RSPQ_LVL_W-1:0]   queue_level,
   output cafr_pkg::rsp_push_type            queue_push,
   output cafr_pkg::store_status_type        status
);
   import cafr_pkg::*;

   logic [31:0]           mem [MAX_WORDS];
   logic [31:0]           rd_data_ff;
   logic                  active_ff;
   logic                  active_in;
   logic [CW-1:0]         idx_ff;
   logic [CW-1:0]         idx_in;
   logic [CW-1:0]         cnt_ff;
   logic [CW-1:0]         cnt_in;
   logic                  inflight_ff;
   logic                  rd_last_ff;
   logic [CW-1:0]         idx_next;
   logic [RSPQ_LVL_W-1:0] reserved;
   logic                  room;
   logic                  issue;
   logic                  issue_last;

   // A queue slot is reserved for a read whose data is still on its way.
   assign reserved   = queue_level + RSPQ_LVL_W'(inflight_ff);
   assign room       = (reserved < RSPQ_LVL_W'(RSPQ_DEPTH));
   assign issue      = active_ff && room;
   assign idx_next   = idx_ff + CW'(1);
   assign issue_last = issue && (idx_next == cnt_ff);

   assign status.room     = room;
   assign status.draining = active_ff || inflight_ff;

   always_comb begin
      if (inflight_ff) begin
         queue_push.valid           = 1'b1;
         queue_push.item.kind       = KIND_WORD;
         queue_push.item.word_value = rd_data_ff;
         queue_push.item.last       = rd_last_ff;
      end else begin
         queue_push = parser_push;
      end
   end

   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      if (drain_go) begin
         active_in = 1'b1;
         idx_in    = '0;
         cnt_in    = drain_count;
      end else if (issue) begin
         idx_in = idx_next;
         if (issue_last) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         inflight_ff <= 1'b0;
         rd_last_ff  <= 1'b0;
         idx_ff      <= '0;
         cnt_ff      <= '0;
      end else begin
         active_ff   <= active_in;
         inflight_ff <= issue;
         rd_last_ff  <= issue_last;
         idx_ff      <= idx_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (issue) begin
         rd_data_ff <= mem[idx_ff[AW-1:0]];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/cafr_frame_parser.sv =====
// Frame parser: phases, running hashes, word tokenizer and reply handling.
// Writes words to the word store and requests the drain. Depends on cafr_pkg.
`default_nettype none

module cafr_frame_parser #(
   parameter  int MAX_WORDS = cafr_pkg::CAFR_MAX_WORDS,
   localparam int AW        = $clog2(MAX_WORDS),
   localparam int CW        = $clog2(MAX_WORDS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_fire,
   input  cafr_pkg::req_type             req_item,
   input  logic [31:0]                   station_address,
   input  logic [7:0]                    nak_retry_limit,
   input  cafr_pkg::store_status_type    store_status,
   output logic                          hold,
   output logic                          wr_en,
   output logic [AW-1:0]                 wr_addr,
   output logic [31:0]                   wr_data,
   output logic                          drain_go,
   output logic [CW-1:0]                 drain_count,
   output cafr_pkg::rsp_push_type        push
);
   import cafr_pkg::*;

   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_WORDS);

   phase_type    phase_ff;
   phase_type    phase_in;
   logic [7:0]   rx_sum_ff, rx_sum_in;
   logic [7:0]   rx_mix_ff, rx_mix_in;
   logic [7:0]   sum_ff, sum_in;
   logic [7:0]   mix_ff, mix_in;
   logic [7:0]   pos_ff, pos_in;
   logic         await_ff, await_in;
   logic [7:0]   resend_ff, resend_in;
   logic         busy_ff, busy_in;
   logic [31:0]  tok_val_ff, tok_val_in;
   logic         tok_seen_ff, tok_seen_in;
   logic         tok_neg_ff, tok_neg_in;
   logic         tok_stop_ff, tok_stop_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]  first_ff, first_in;
   logic         hash_ok_ff, hash_ok_in;

   logic [7:0]   rx;
   logic         is_data;
   logic         reply_ack;
   logic         reply_nak;
   logic         frame_take;
   logic         at_etx;
   logic         pay_byte;
   logic         end_tok;
   logic         store_tok;
   logic         parse;
   logic         is_digit;
   logic [31:0]  tok_word;
   logic [7:0]   mix_sum;
   logic [7:0]   pos_inc;
   logic [15:0]  mix_prod;
   logic         check_done;

   function automatic logic [7:0] bump_hash(input logic [7:0] h);
      if (h == CH_ETX || h == CH_CR) begin
         return h + 8'd1;
      end
      return h;
   endfunction

   assign rx         = req_item.rx_byte;
   assign is_data    = req_fire && !req_item.mode && !busy_ff;
   assign reply_ack  = is_data && await_ff && (rx == CH_ACK);
   assign reply_nak  = is_data && await_ff && (rx == CH_NAK);
   assign frame_take = is_data && !reply_ack && !reply_nak;
   assign at_etx     = frame_take && (phase_ff == PH_PAYLOAD) && (rx == CH_ETX);
   assign pay_byte   = frame_take && (phase_ff == PH_PAYLOAD) && (rx != CH_ETX);
   assign is_digit   = rx inside {[CH_ZERO:CH_NINE]};

   // A space at a nonzero position ends a word; the frame end stores only a begun token.
   assign end_tok   = at_etx || (pay_byte && (pos_ff != 8'd0) && (rx == CH_SPACE));
   assign store_tok = at_etx ? tok_seen_ff : end_tok;
   assign parse     = pay_byte && (pos_ff != 8'd0) && (rx != CH_SPACE);
   assign tok_word  = tok_neg_ff ? (32'd0 - tok_val_ff) : tok_val_ff;

   assign wr_en   = store_tok && (count_ff < MAX_CNT);
   assign wr_addr = count_ff[AW-1:0];
   assign wr_data = tok_word;

   assign mix_sum  = mix_ff + rx;
   assign pos_inc  = pos_ff + 8'd1;
   assign mix_prod = mix_sum * pos_inc;

   assign hold       = (phase_ff == PH_CHECK);
   assign check_done = hold && store_status.room;

   always_comb begin
      phase_in = phase_ff;
      if (check_done) begin
         phase_in = PH_IDLE;
      end else if (frame_take) begin
         case (phase_ff)
            PH_IDLE: begin
               if (rx == CH_STX) begin
                  phase_in = PH_SKIP1;
               end
            end
            PH_SKIP1:   phase_in = PH_SUM;
            PH_SUM:     phase_in = PH_SKIP2;
            PH_SKIP2:   phase_in = PH_MIX;
            PH_MIX:     phase_in = PH_PAYLOAD;
            PH_PAYLOAD: begin
               if (rx == CH_ETX) begin
                  phase_in = PH_CHECK;
               end
            end
            default:    phase_in = PH_IDLE;
         endcase
      end
   end

   always_comb begin
      logic sign_taken;
      sign_taken  = 1'b0;
      rx_sum_in   = rx_sum_ff;
      rx_mix_in   = rx_mix_ff;
      sum_in      = sum_ff;
      mix_in      = mix_ff;
      pos_in      = pos_ff;
      await_in    = await_ff;
      resend_in   = resend_ff;
      busy_in     = busy_ff;
      tok_val_in  = tok_val_ff;
      tok_seen_in = tok_seen_ff;
      tok_neg_in  = tok_neg_ff;
      tok_stop_in = tok_stop_ff;
      count_in    = count_ff;
      first_in    = first_ff;
      hash_ok_in  = hash_ok_ff;
      drain_go    = 1'b0;
      drain_count = count_ff;
      push.valid           = 1'b0;
      push.item.kind       = KIND_ACK;
      push.item.word_value = 32'd0;
      push.item.last       = 1'b0;

      if (req_fire && req_item.mode) begin
         busy_in = 1'b0;
      end

      if (reply_ack) begin
         await_in  = 1'b0;
         resend_in = 8'd0;
      end

      if (reply_nak) begin
         if (resend_ff < nak_retry_limit) begin
            resend_in      = resend_ff + 8'd1;
            push.valid     = 1'b1;
            push.item.kind = KIND_RESEND;
            push.item.last = 1'b1;
         end else begin
            await_in  = 1'b0;
            resend_in = 8'd0;
         end
      end

      if (frame_take) begin
         case (phase_ff)
            PH_IDLE: begin
               if (rx == CH_STX) begin
                  sum_in      = 8'd0;
                  mix_in      = 8'd0;
                  pos_in      = 8'd0;
                  tok_val_in  = 32'd0;
                  tok_seen_in = 1'b0;
                  tok_neg_in  = 1'b0;
                  tok_stop_in = 1'b0;
                  count_in    = '0;
               end
            end
            PH_SUM:  rx_sum_in = rx;
            PH_MIX:  rx_mix_in = rx;
            default: begin
            end
         endcase
      end

      if (pay_byte) begin
         sum_in = sum_ff + rx;
         mix_in = mix_prod[7:0];
         pos_in = pos_inc;
      end

      if (parse) begin
         if (!tok_seen_ff) begin
            tok_seen_in = 1'b1;
            if (rx == CH_MINUS) begin
               tok_neg_in = 1'b1;
               sign_taken = 1'b1;
            end else if (rx == CH_PLUS) begin
               sign_taken = 1'b1;
            end
         end
         if (!sign_taken && !tok_stop_ff) begin
            if (is_digit) begin
               tok_val_in = (tok_val_ff << 3) + (tok_val_ff << 1) + {28'd0, rx[3:0]};
            end else begin
               tok_stop_in = 1'b1;
            end
         end
      end

      if (end_tok) begin
         tok_val_in  = 32'd0;
         tok_seen_in = 1'b0;
         tok_neg_in  = 1'b0;
         tok_stop_in = 1'b0;
      end

      if (wr_en) begin
         count_in = count_ff + CW'(1);
         if (count_ff == '0) begin
            first_in = tok_word;
         end
      end

      if (at_etx) begin
         hash_ok_in = (bump_hash(sum_ff) == rx_sum_ff) && (bump_hash(mix_ff) == rx_mix_ff);
         pos_in     = 8'd0;
         resend_in  = 8'd0;
      end

      // The frame end is judged in the check phase, once the final word is in place.
      if (check_done) begin
         if (!hash_ok_ff) begin
            push.valid     = 1'b1;
            push.item.kind = KIND_NAK;
            push.item.last = 1'b1;
         end else if ((count_ff != '0) && (first_ff == station_address)) begin
            push.valid     = 1'b1;
            push.item.kind = KIND_ACK;
            drain_go       = 1'b1;
            busy_in        = 1'b1;
            await_in       = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         rx_sum_ff   <= 8'd0;
         rx_mix_ff   <= 8'd0;
         sum_ff      <= 8'd0;
         mix_ff      <= 8'd0;
         pos_ff      <= 8'd0;
         await_ff    <= 1'b0;
         resend_ff   <= 8'd0;
         busy_ff     <= 1'b0;
         tok_val_ff  <= 32'd0;
         tok_seen_ff <= 1'b0;
         tok_neg_ff  <= 1'b0;
         tok_stop_ff <= 1'b0;
         count_ff    <= '0;
         hash_ok_ff  <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         rx_sum_ff   <= rx_sum_in;
         rx_mix_ff   <= rx_mix_in;
         sum_ff      <= sum_in;
         mix_ff      <= mix_in;
         pos_ff      <= pos_in;
         await_ff    <= await_in;
         resend_ff   <= resend_in;
         busy_ff     <= busy_in;
         tok_val_ff  <= tok_val_in;
         tok_seen_ff <= tok_seen_in;
         tok_neg_ff  <= tok_neg_in;
         tok_stop_ff <= tok_stop_in;
         count_ff    <= count_in;
         hash_ok_ff  <= hash_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/checked_ascii_frame_receiver_unit.sv =====
// Checked ASCII frame receiver: each request is one byte or a decode-done mark.
// Requests are taken back to back while req_stall is low; a result it causes goes through
// the response queue. A frame end is checked in the check phase: NAK is queued on a hash
// mismatch, ACK if the first word is the station address; the stored words follow one per
// cycle while the queue has room, via a registered read of the word memory. The next request
// waits in the check, in the drain after an ACK, and while the queue is full. Reset is
// synchronous, active high, and clears all control state; the word memory is not cleared.
`default_nettype none

module checked_ascii_frame_receiver_unit #(
   parameter  int MAX_WORDS = cafr_pkg::CAFR_MAX_WORDS,
   localparam int AW        = $clog2(MAX_WORDS),
   localparam int CW        = $clog2(MAX_WORDS + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  cafr_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output cafr_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cafr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [31:0]                         csr_wdata
);
   import cafr_pkg::*;

   logic [31:0]            station_address_ff;
   logic [7:0]             nak_retry_limit_ff;
   logic                   req_fire;
   logic                   hold;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [31:0]            wr_data;
   logic                   drain_go;
   logic [CW-1:0]          drain_count;
   rsp_push_type           parser_push;
   rsp_push_type           queue_push;
   store_status_type       store_status;
   logic [RSPQ_LVL_W-1:0]  queue_level;

   assign csr_ready = 1'b1;
   assign req_stall = hold || store_status.draining || !store_status.room;
   assign req_fire  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         station_address_ff <= STATION_ADDRESS_RESET;
         nak_retry_limit_ff <= NAK_RETRY_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_STATION_ADDRESS) begin
            station_address_ff <= csr_wdata;
         end else if (csr_index == CSR_NAK_RETRY_LIMIT) begin
            nak_retry_limit_ff <= csr_wdata[7:0];
         end
      end
   end

   cafr_frame_parser #(
      .MAX_WORDS (MAX_WORDS)
   ) u_parser (
      .clock           (clock),
      .reset           (reset),
      .req_fire        (req_fire),
      .req_item        (req_data),
      .station_address (station_address_ff),
      .nak_retry_limit (nak_retry_limit_ff),
      .store_status    (store_status),
      .hold            (hold),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .drain_go        (drain_go),
      .drain_count     (drain_count),
      .push            (parser_push)
   );

   cafr_word_store #(
      .MAX_WORDS (MAX_WORDS)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .drain_go    (drain_go),
      .drain_count (drain_count),
      .parser_push (parser_push),
      .queue_level (queue_level),
      .queue_push  (queue_push),
      .status      (store_status)
   );

   cafr_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .level     (queue_level),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== sim/checked_ascii_frame_receiver_unit_test.sv =====
// Self-checking testbench for checked_ascii_frame_receiver_unit: it feeds framed byte
// traffic and host replies, predicts every response in-line and checks each one.
// Depends on cafr_pkg and the receiver RTL only.
`timescale 1ns / 100ps

module checked_ascii_frame_receiver_unit_test;
   import cafr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = CAFR_MAX_WORDS + 8;
   localparam int HOLD_AT = 60;
   localparam int HOLD_CYCLES = 400;

   typedef logic [7:0] octet_q_type[$];

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_STATION_ADDRESS;
   logic [31:0] csr_wdata = 32'd0;

   req_type rx_backlog[$];
   rsp_type owed_responses[$];
   rsp_type want_rsp;
   octet_q_type payload_text;
   octet_q_type frame_text;

   int failures = 0;
   int items_sent = 0;
   int cycle_count = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   logic calm;

   // Receiver state as the testbench sees it.
   logic [31:0] cfg_station = STATION_ADDRESS_RESET;
   logic [7:0] cfg_retry = NAK_RETRY_LIMIT_RESET;
   phase_type rx_phase = PH_IDLE;
   logic [7:0] rcv_sum = 8'd0;
   logic [7:0] rcv_mix = 8'd0;
   logic [7:0] acc_sum = 8'd0;
   logic [7:0] acc_mix = 8'd0;
   logic [7:0] pay_pos = 8'd0;
   bit awaiting = 1'b0;
   logic [7:0] resends = 8'd0;
   bit host_busy = 1'b0;
   logic [31:0] tok_val = 32'd0;
   bit tok_seen = 1'b0;
   bit tok_neg = 1'b0;
   bit tok_stop = 1'b0;
   int word_total = 0;
   logic [31:0] frame_words[CAFR_MAX_WORDS];

   checked_ascii_frame_receiver_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   assign calm = (items_sent >= 200) && (items_sent < 300);

   function automatic logic [7:0] bumped(logic [7:0] h);
      return (h == CH_ETX || h == CH_CR) ? h + 8'd1 : h;
   endfunction

   function automatic void owe(kind_type k, logic [31:0] v, logic l);
      rsp_type r;
      r.kind = k;
      r.word_value = v;
      r.last = l;
      owed_responses.push_back(r);
   endfunction

   function automatic void close_token(bit forced);
      logic [31:0] v;
      if (forced || tok_seen) begin
         v = tok_neg ? 32'd0 - tok_val : tok_val;
         if (word_total < CAFR_MAX_WORDS) begin
            frame_words[word_total] = v;
            word_total++;
         end
      end
      tok_val = 32'd0;
      tok_seen = 1'b0;
      tok_neg = 1'b0;
      tok_stop = 1'b0;
   endfunction

   // Decimal parsing in the manner of atoi: optional sign, digits, stop at anything else.
   function automatic void take_char(logic [7:0] c);
      if (!tok_seen) begin
         tok_seen = 1'b1;
         if (c == CH_MINUS) begin
            tok_neg = 1'b1;
            return;
         end
         if (c == CH_PLUS) return;
      end
      if (tok_stop) return;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         tok_val = tok_val * 32'd10 + 32'(c - CH_ZERO);
      end else begin
         tok_stop = 1'b1;
      end
   endfunction

   function automatic void advance_receiver(req_type r);
      logic [7:0] c;
      int i;
      c = r.rx_byte;
      if (r.mode) begin
         host_busy = 1'b0;
         return;
      end
      if (host_busy) return;
      if (awaiting && c == CH_ACK) begin
         awaiting = 1'b0;
         resends = 8'd0;
         return;
      end
      if (awaiting && c == CH_NAK) begin
         if (resends < cfg_retry) begin
            resends++;
            owe(KIND_RESEND, 32'd0, 1'b1);
         end else begin
            awaiting = 1'b0;
            resends = 8'd0;
         end
         return;
      end
      case (rx_phase)
         PH_IDLE: begin
            if (c == CH_STX) begin
               acc_sum = 8'd0;
               acc_mix = 8'd0;
               pay_pos = 8'd0;
               tok_val = 32'd0;
               tok_seen = 1'b0;
               tok_neg = 1'b0;
               tok_stop = 1'b0;
               word_total = 0;
               rx_phase = PH_SKIP1;
            end
         end
         PH_SKIP1: rx_phase = PH_SUM;
         PH_SUM: begin
            rcv_sum = c;
            rx_phase = PH_SKIP2;
         end
         PH_SKIP2: rx_phase = PH_MIX;
         PH_MIX: begin
            rcv_mix = c;
            rx_phase = PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            if (c == CH_ETX) begin
               close_token(1'b0);
               acc_sum = bumped(acc_sum);
               acc_mix = bumped(acc_mix);
               if (acc_sum == rcv_sum && acc_mix == rcv_mix) begin
                  if (word_total > 0 && frame_words[0] == cfg_station) begin
                     host_busy = 1'b1;
                     awaiting = 1'b1;
                     owe(KIND_ACK, 32'd0, word_total == 0);
                     for (i = 0; i < word_total; i++) begin
                        owe(KIND_WORD, frame_words[i], i + 1 == word_total);
                     end
                  end
               end else begin
                  owe(KIND_NAK, 32'd0, 1'b1);
               end
               rx_phase = PH_IDLE;
               pay_pos = 8'd0;
               resends = 8'd0;
            end else begin
               acc_sum = acc_sum + c;
               acc_mix = 8'((32'(acc_mix) + 32'(c)) * (32'(pay_pos) + 32'd1));
               // The byte at position zero, including after a wrap, is hashed only.
               if (pay_pos != 8'd0) begin
                  if (c == CH_SPACE) close_token(1'b1);
                  else take_char(c);
               end
               pay_pos = pay_pos + 8'd1;
            end
         end
         default: rx_phase = PH_IDLE;
      endcase
   endfunction

   // Request driver: valid is held with a steady payload until the block takes it.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            advance_receiver(req_data);
            items_sent <= items_sent + 1;
         end
         if (!req_valid || !req_stall) begin
            if (rx_backlog.size() > 0 && (calm || $urandom_range(99) >= 6)) begin
               req_valid <= 1'b1;
               req_data <= rx_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response side back-pressure, with one long hold so the block backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && items_sent >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 6);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_responses.size() == 0) begin
            failures++;
            $display("%0t: response with nothing expected: kind %0d value %0h last %0b",
                     $time, rsp_data.kind, rsp_data.word_value, rsp_data.last);
         end else begin
            want_rsp = owed_responses.pop_front();
            if (rsp_data.kind !== want_rsp.kind) begin
               failures++;
               $display("%0t: kind mismatch, expected %0d, actual %0d",
                        $time, want_rsp.kind, rsp_data.kind);
            end
            if (rsp_data.word_value !== want_rsp.word_value) begin
               failures++;
               $display("%0t: word_value mismatch, expected %0h, actual %0h",
                        $time, want_rsp.word_value, rsp_data.word_value);
            end
            if (rsp_data.last !== want_rsp.last) begin
               failures++;
               $display("%0t: last mismatch, expected %0b, actual %0b",
                        $time, want_rsp.last, rsp_data.last);
            end
         end
      end
   end

   function automatic void send_byte(logic [7:0] b);
      rx_backlog.push_back('{mode: 1'b0, rx_byte: b});
   endfunction

   function automatic void send_done();
      rx_backlog.push_back('{mode: 1'b1, rx_byte: 8'($urandom_range(255))});
   endfunction

   function automatic void append_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) payload_text.push_back(s[i]);
   endfunction

   function automatic string word_text();
      int unsigned pick;
      pick = $urandom_range(9);
      case (pick)
         0: return $sformatf("%0d", $urandom_range(99));
         1, 2: return $sformatf("%0d", $urandom);
         3: return $sformatf("-%0d", $urandom);
         4: return $sformatf("+%0d", $urandom_range(9999));
         5: return $sformatf("%0d%0d", $urandom, $urandom_range(99, 10));
         6: return $sformatf("%0dx%0d", $urandom_range(999), $urandom_range(9));
         7: return "";
         8: return ($urandom_range(1) == 1) ? "-" : "q";
         default: return $sformatf("%0d", $urandom_range(9));
      endcase
   endfunction

   function automatic string address_text(logic [31:0] a);
      case ($urandom_range(3))
         0: return $sformatf("+%0d", a);
         1: return $sformatf("-%0d", 32'd0 - a);
         2: return $sformatf("00%0d", a);
         default: return $sformatf("%0d", a);
      endcase
   endfunction

   // Builds a payload: a skipped lead byte, the address word, then further words.
   function automatic void compose_payload(int nwords, bit addr_ok);
      logic [7:0] lead;
      int k;
      do lead = 8'($urandom_range(255)); while (lead == CH_ETX);
      payload_text.delete();
      payload_text.push_back(lead);
      if (nwords == 0) return;
      if (addr_ok) append_text(address_text(cfg_station));
      else append_text($sformatf("%0d", cfg_station ^ (32'd1 << $urandom_range(31))));
      for (k = 1; k < nwords; k++) begin
         payload_text.push_back(CH_SPACE);
         append_text(word_text());
      end
      if ($urandom_range(3) == 0) payload_text.push_back(CH_SPACE);
   endfunction

   // Wraps the payload in a frame with its two hashes and queues the first keep bytes.
   function automatic void send_frame(bit corrupt, int keep);
      logic [7:0] s;
      logic [7:0] m;
      int i;
      s = 8'd0;
      m = 8'd0;
      foreach (payload_text[j]) begin
         s = s + payload_text[j];
         m = 8'((32'(m) + 32'(payload_text[j])) * ((j % 256) + 1));
      end
      s = bumped(s);
      m = bumped(m);
      if (corrupt) begin
         if ($urandom_range(1) == 1) s = s ^ (8'd1 << $urandom_range(7));
         else m = m ^ (8'd1 << $urandom_range(7));
      end
      frame_text.delete();
      frame_text.push_back(CH_STX);
      frame_text.push_back(8'($urandom_range(255)));
      frame_text.push_back(s);
      frame_text.push_back(8'($urandom_range(255)));
      frame_text.push_back(m);
      foreach (payload_text[j]) frame_text.push_back(payload_text[j]);
      frame_text.push_back(CH_ETX);
      if (keep < 0 || keep > frame_text.size()) keep = frame_text.size();
      for (i = 0; i < keep; i++) send_byte(frame_text[i]);
   endfunction

   // A matching frame followed by the host's decode-done and an optional reply sequence.
   function automatic void send_exchange(int nwords);
      int n;
      compose_payload(nwords, 1'b1);
      send_frame(1'b0, -1);
      n = $urandom_range(2);
      repeat (n) send_byte(($urandom_range(1) == 1) ? CH_NAK : 8'($urandom_range(255)));
      send_done();
      case ($urandom_range(3))
         0: send_byte(CH_ACK);
         1: begin
            repeat ($urandom_range(4, 1)) send_byte(CH_NAK);
            send_byte(CH_ACK);
         end
         2: repeat ($urandom_range(4, 1)) send_byte(CH_NAK);
         default: ;
      endcase
   endfunction

   function automatic void directed_burst();
      send_byte(8'hFF);
      send_byte(CH_ETX);
      send_byte(8'h00);
      rx_backlog.push_back('{mode: 1'b1, rx_byte: 8'hFF});
      // Final token ended by ETX with no trailing space.
      payload_text.delete();
      append_text("Z1");
      send_frame(1'b0, -1);
      send_byte(CH_NAK);
      send_done();
      // Three resends, then the fourth NAK finds the retries spent.
      repeat (4) send_byte(CH_NAK);
      append_text(" ");
      send_frame(1'b1, -1);
   endfunction

   function automatic void random_traffic(int quota, bit with_long);
      int made;
      int prior;
      int pick;
      made = 0;
      if (with_long) begin
         // Payload past 256 bytes wraps the position and overfills the word store.
         prior = rx_backlog.size();
         compose_payload(1, 1'b1);
         payload_text.push_back(CH_SPACE);
         repeat (256) begin
            payload_text.push_back(($urandom_range(3) == 0) ? CH_SPACE
                                   : 8'(CH_ZERO + $urandom_range(9)));
         end
         send_frame(1'b0, -1);
         send_done();
         send_byte(CH_ACK);
         made = rx_backlog.size() - prior;
      end
      while (made < quota) begin
         prior = rx_backlog.size();
         pick = $urandom_range(99);
         if (pick < 50) begin
            send_exchange($urandom_range(6, 1));
         end else if (pick < 62) begin
            compose_payload($urandom_range(6, 1), 1'b1);
            send_frame(1'b1, -1);
         end else if (pick < 70) begin
            compose_payload($urandom_range(6, 1), 1'b0);
            send_frame(1'b0, -1);
         end else if (pick < 76) begin
            compose_payload(0, 1'b1);
            if ($urandom_range(1) == 1) payload_text.delete();
            send_frame(1'b0, -1);
         end else if (pick < 84) begin
            compose_payload($urandom_range(6, 1), 1'b1);
            send_frame(1'b0, $urandom_range(6, 1));
         end else begin
            repeat ($urandom_range(5, 1)) begin
               rx_backlog.push_back('{mode: ($urandom_range(3) == 0),
                                      rx_byte: 8'($urandom_range(255))});
            end
         end
         made += rx_backlog.size() - prior;
      end
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_STATION_ADDRESS) cfg_station = val;
      else cfg_retry = val[7:0];
   endtask

   task automatic wait_quiet();
      while (rx_backlog.size() != 0 || req_valid || owed_responses.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("checked_ascii_frame_receiver_unit_test failed");
      $finish;
   end

   initial begin
      int phase_no;
      int quota[5];
      quota = '{15, 10, 10, 0, 10};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (phase_no = 0; phase_no < 5; phase_no++) begin
         if (phase_no > 0) begin
            wait_quiet();
            case (phase_no)
               1: begin
                  write_reg(CSR_STATION_ADDRESS, 32'd0);
                  write_reg(CSR_NAK_RETRY_LIMIT, 32'd0);
               end
               2: begin
                  write_reg(CSR_STATION_ADDRESS, 32'hFFFF_FFFF);
                  write_reg(CSR_NAK_RETRY_LIMIT, 32'd255);
               end
               3: begin
                  write_reg(CSR_STATION_ADDRESS, $urandom);
                  write_reg(CSR_NAK_RETRY_LIMIT, 32'd1);
               end
               default: begin
                  write_reg(CSR_STATION_ADDRESS, $urandom_range(999));
                  write_reg(CSR_NAK_RETRY_LIMIT, 32'd2);
               end
            endcase
         end
         @(negedge clock);
         if (phase_no == 0) directed_burst();
         random_traffic(quota[phase_no], phase_no == 3);
         // Leave the receiver free and out of the reply wait before the next settings.
         send_done();
         send_byte(CH_ACK);
      end
      wait_quiet();
      if (failures == 0) begin
         $display("checked_ascii_frame_receiver_unit_test passed");
      end else begin
         $display("checked_ascii_frame_receiver_unit_test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/cafr_pkg.sv
rtl/core/cafr_rsp_queue.sv
rtl/core/cafr_word_store.sv
rtl/core/cafr_frame_parser.sv
rtl/core/checked_ascii_frame_receiver_unit.sv
sim/checked_ascii_frame_receiver_unit_test.sv
